// ===== rtl/core/ssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Input item: one scan tick
  typedef struct packed {
    logic [7:0] shown_value;
    logic [1:0] display_mode;
  } ssd_in_t;

  // Result item: one driven digit
  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_enable;
  } ssd_out_t;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_SDEC = 2'd2,
    MODE_BIN  = 2'd3
  } ssd_mode_t;

  // Scan positions, units digit on the right
  localparam logic [1:0] POS_UNITS    = 2'd0;
  localparam logic [1:0] POS_TENS     = 2'd1;
  localparam logic [1:0] POS_HUNDREDS = 2'd2;
  localparam logic [1:0] POS_TOP      = 2'd3;

  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_H     = 8'h3B;
  localparam logic [7:0] SEG_MINUS = 8'h01;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'h7E;
      4'h1: g = 8'h12;
      4'h2: g = 8'h5D;
      4'h3: g = 8'h57;
      4'h4: g = 8'h33;
      4'h5: g = 8'h67;
      4'h6: g = 8'h6F;
      4'h7: g = 8'h52;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h77;
      4'hA: g = 8'h7B;
      4'hB: g = 8'h2F;
      4'hC: g = 8'h6C;
      4'hD: g = 8'h1F;
      4'hE: g = 8'h6D;
      4'hF: g = 8'h69;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] pair_glyph(input logic [1:0] b);
    logic [7:0] g;
    case (b)
      2'd0: g = 8'h00;
      2'd1: g = 8'h12;
      2'd2: g = 8'h28;
      2'd3: g = 8'h3A;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssd_decimal.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte into three decimal glyphs, leading zeros blanked.
module ssd_decimal (
  input  logic [7:0] mag,
  output logic [7:0] seg_units,
  output logic [7:0] seg_tens,
  output logic [7:0] seg_hund
);
  import ssd_pkg::*;

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  units_w;

  always_comb begin
    if (mag >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(mag - 8'd200);
    end else if (mag >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(mag - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = mag[6:0];
    end
  end

  // rem / 10 as rem * 205 >> 11, exact for rem below 100
  assign prod     = 15'(rem) * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign units_w  = rem - tens_x10;

  assign seg_units = glyph(units_w[3:0]);
  assign seg_tens  = (mag < 8'd10)  ? SEG_BLANK : glyph(tens);
  assign seg_hund  = (mag < 8'd100) ? SEG_BLANK : glyph({2'b00, hund});

endmodule

`default_nettype wire

// ===== rtl/core/ssd_pattern.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Segment pattern and cathode select for one tick at one scan position.
module ssd_pattern (
  input  ssd_pkg::ssd_in_t  item,
  input  logic [1:0]        pos,
  output ssd_pkg::ssd_out_t result
);
  import ssd_pkg::*;

  logic       neg;
  logic [7:0] mag;
  logic [7:0] seg_units;
  logic [7:0] seg_tens;
  logic [7:0] seg_hund;
  logic [7:0] dec_seg;
  logic [1:0] pair_bits;
  logic [7:0] seg;

  // Two's complement magnitude only in signed mode; -128 maps to 128
  assign neg = (ssd_mode_t'(item.display_mode) == MODE_SDEC) && item.shown_value[7];
  assign mag = neg ? 8'(-item.shown_value) : item.shown_value;

  ssd_decimal u_dec (
    .mag       (mag),
    .seg_units (seg_units),
    .seg_tens  (seg_tens),
    .seg_hund  (seg_hund)
  );

  always_comb begin
    case (pos)
      POS_UNITS:    dec_seg = seg_units;
      POS_TENS:     dec_seg = seg_tens;
      POS_HUNDREDS: dec_seg = seg_hund;
      default:      dec_seg = SEG_BLANK;
    endcase
  end

  always_comb begin
    case (pos)
      POS_UNITS:    pair_bits = item.shown_value[1:0];
      POS_TENS:     pair_bits = item.shown_value[3:2];
      POS_HUNDREDS: pair_bits = item.shown_value[5:4];
      default:      pair_bits = item.shown_value[7:6];
    endcase
  end

  always_comb begin
    case (ssd_mode_t'(item.display_mode))
      MODE_BIN: seg = pair_glyph(pair_bits);
      MODE_HEX: begin
        case (pos)
          POS_TOP:      seg = SEG_H;
          POS_HUNDREDS: seg = SEG_BLANK;
          POS_TENS:     seg = glyph(item.shown_value[7:4]);
          default:      seg = glyph(item.shown_value[3:0]);
        endcase
      end
      MODE_SDEC: begin
        case (pos)
          POS_TOP:   seg = neg ? SEG_MINUS : SEG_BLANK;
          POS_UNITS: seg = dec_seg | SEG_DP;
          default:   seg = dec_seg;
        endcase
      end
      default: seg = dec_seg;
    endcase
  end

  assign result.segments     = seg;
  assign result.digit_enable = 4'(4'b1000 >> pos);

endmodule

`default_nettype wire

// ===== rtl/core/seven_segment_scan_driver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                         | Payload
// ---------+-------------------------------+-------------------------------------
// input    | in_valid, in_ready, in_data   | shown_value[7:0], display_mode[1:0]
// result   | out_valid, out_ready, out_data| segments[7:0], digit_enable[3:0]
//
// One item per cycle sustained while out_ready is high; out_valid rises when
// the item leaves the input register via pattern logic for the result register.
// Reset (rst_n low, synchronous) empties both stages and sets the scan
// position to the units digit.
// The scan position steps once per accepted input item, not per clock.
// With out_ready low the result register holds and one more item can wait in
// the input register; in_ready drops only when both are full.
module seven_segment_scan_driver_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssd_pkg::ssd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssd_pkg::ssd_out_t  out_data
);
  import ssd_pkg::*;

  // scan position for the next accepted item
  logic [1:0] pos_r;
  logic [1:0] pos_nxt;

  // input stage
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  ssd_in_t    s1_data_r;
  logic [1:0] s1_pos_r;

  // result stage
  logic       out_valid_r;
  logic       out_valid_nxt;
  ssd_out_t   out_data_r;
  ssd_out_t   out_data_nxt;

  logic in_acc;
  logic out_free;
  logic s1_adv;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  assign pos_nxt       = in_acc ? 2'(pos_r + 2'd1) : pos_r;
  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  ssd_pattern u_pattern (
    .item   (s1_data_r),
    .pos    (s1_pos_r),
    .result (out_data_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_UNITS;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
      s1_pos_r  <= pos_r;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/ssd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ssd_pkg::ssd_out_t  out_data
);
  import ssd_pkg::*;

  // expected position of the next delivered item
  logic [1:0] exp_pos_r;
  logic [1:0] exp_pos_nxt;

  assign exp_pos_nxt = (out_valid && out_ready) ? 2'(exp_pos_r + 2'd1) : exp_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pos_r <= POS_UNITS;
    end else begin
      exp_pos_r <= exp_pos_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_data.digit_enable))
    else $error("digit select not one-hot");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.digit_enable == 4'(4'b1000 >> exp_pos_r))
    else $error("digit select out of scan order");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result side empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind seven_segment_scan_driver_top ssd_checker u_ssd_checker (.*);

`default_nettype wire

// ===== test/tb_seven_segment_scan_driver_top.sv =====
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver_top;
  import ssd_pkg::*;

  // Random ticks after the directed table; the last stretch runs with no idling
  localparam int RAND_TICKS = 1525;
  localparam int QUIET_TAIL = 150;

  // Glyphs for 0..F, entry 0 in the low byte
  localparam logic [127:0] DIGIT_ROM = {
    8'h69, 8'h6D, 8'h1F, 8'h6C, 8'h2F, 8'h7B, 8'h77, 8'h7F,
    8'h52, 8'h6F, 8'h67, 8'h33, 8'h57, 8'h5D, 8'h12, 8'h7E
  };
  // Two-bit groups for binary mode
  localparam logic [31:0] PAIR_ROM = {8'h3A, 8'h28, 8'h12, 8'h00};

  localparam logic [3:0] EN_UNITS    = 4'b1000;
  localparam logic [3:0] EN_TENS     = 4'b0100;
  localparam logic [3:0] EN_HUNDREDS = 4'b0010;
  localparam logic [3:0] EN_TOP      = 4'b0001;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ssd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  ssd_out_t out_data;

  seven_segment_scan_driver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Predictor state: scan position advances once per accepted item
  logic [1:0] scan_pos = POS_UNITS;
  ssd_out_t   expected_digits [$];
  int         errors = 0;

  // Percent chance per item / per cycle of starting an idle burst, both sides
  int idle_pct = 0;

  // Decimal digit of a magnitude, leading zeros blanked above the units digit
  function automatic logic [7:0] decimal_glyph(input int mag, input logic [1:0] pos);
    int d;
    if (pos == POS_HUNDREDS) begin
      if (mag < 100) return SEG_BLANK;
      d = (mag / 100) % 10;
    end else if (pos == POS_TENS) begin
      if (mag < 10) return SEG_BLANK;
      d = (mag / 10) % 10;
    end else begin
      d = mag % 10;
    end
    return DIGIT_ROM[d*8 +: 8];
  endfunction

  // Expected digit for one tick at a given scan position
  function automatic ssd_out_t scan_pattern(input ssd_in_t tick, input logic [1:0] pos);
    ssd_out_t   r;
    logic [1:0] pair;
    logic [3:0] nib;
    logic       neg;
    int         mag;
    r.digit_enable = EN_UNITS >> pos;
    case (tick.display_mode)
      MODE_BIN: begin
        pair = 2'(tick.shown_value >> (2 * pos));
        r.segments = PAIR_ROM[pair*8 +: 8];
      end
      MODE_HEX: begin
        nib = (pos == POS_TENS) ? tick.shown_value[7:4] : tick.shown_value[3:0];
        if (pos == POS_TOP) r.segments = SEG_H;
        else if (pos == POS_HUNDREDS) r.segments = SEG_BLANK;
        else r.segments = DIGIT_ROM[nib*8 +: 8];
      end
      MODE_SDEC: begin
        // two's complement byte; -128 has magnitude 128
        neg = tick.shown_value[7];
        mag = neg ? 256 - int'(tick.shown_value) : int'(tick.shown_value);
        if (pos == POS_TOP) r.segments = neg ? SEG_MINUS : SEG_BLANK;
        else if (pos == POS_UNITS) r.segments = decimal_glyph(mag, pos) | SEG_DP;
        else r.segments = decimal_glyph(mag, pos);
      end
      default: begin
        if (pos == POS_TOP) r.segments = SEG_BLANK;
        else r.segments = decimal_glyph(int'(tick.shown_value), pos);
      end
    endcase
    return r;
  endfunction

  // Directed rows. Where typed is set, seg/en are the hand-written result;
  // otherwise the predictor supplies it. Rows start at the units position.
  typedef struct packed {
    logic [7:0] value;
    ssd_mode_t  mode;
    logic       typed;
    logic [7:0] seg;
    logic [3:0] en;
  } tick_row_t;

  tick_row_t tick_table [25] = '{
    // most negative byte: "-128", point on the 8
    '{8'h80, MODE_SDEC, 1'b1, 8'hFF, EN_UNITS},
    '{8'h80, MODE_SDEC, 1'b1, 8'h5D, EN_TENS},
    '{8'h80, MODE_SDEC, 1'b1, 8'h12, EN_HUNDREDS},
    '{8'h80, MODE_SDEC, 1'b1, 8'h01, EN_TOP},
    // zero, unsigned: only the units digit lit
    '{8'h00, MODE_UDEC, 1'b1, 8'h7E, EN_UNITS},
    '{8'h00, MODE_UDEC, 1'b1, 8'h00, EN_TENS},
    '{8'h00, MODE_UDEC, 1'b1, 8'h00, EN_HUNDREDS},
    '{8'h00, MODE_UDEC, 1'b1, 8'h00, EN_TOP},
    // zero, signed: "0." on the units digit
    '{8'h00, MODE_SDEC, 1'b1, 8'hFE, EN_UNITS},
    '{8'h00, MODE_SDEC, 1'b1, 8'h00, EN_TENS},
    '{8'h00, MODE_SDEC, 1'b1, 8'h00, EN_HUNDREDS},
    '{8'h00, MODE_SDEC, 1'b1, 8'h00, EN_TOP},
    // hex A5: "H A5" with a blank
    '{8'hA5, MODE_HEX,  1'b1, 8'h67, EN_UNITS},
    '{8'hA5, MODE_HEX,  1'b1, 8'h7B, EN_TENS},
    '{8'hA5, MODE_HEX,  1'b1, 8'h00, EN_HUNDREDS},
    '{8'hA5, MODE_HEX,  1'b1, 8'h3B, EN_TOP},
    // binary 11_10_01_00: every pair pattern once
    '{8'hE4, MODE_BIN,  1'b1, 8'h00, EN_UNITS},
    '{8'hE4, MODE_BIN,  1'b1, 8'h12, EN_TENS},
    '{8'hE4, MODE_BIN,  1'b1, 8'h28, EN_HUNDREDS},
    '{8'hE4, MODE_BIN,  1'b1, 8'h3A, EN_TOP},
    // blanking edges and signed extremes, predicted
    '{8'hFF, MODE_SDEC, 1'b0, 8'h00, 4'h0},
    '{8'h7F, MODE_SDEC, 1'b0, 8'h00, 4'h0},
    '{8'd99, MODE_UDEC, 1'b0, 8'h00, 4'h0},
    '{8'd100, MODE_UDEC, 1'b0, 8'h00, 4'h0},
    '{8'd255, MODE_UDEC, 1'b0, 8'h00, 4'h0}
  };

  // Values near the blanking thresholds and the sign boundary
  logic [7:0] edge_values [10] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd99, 8'd100,
                                   8'd127, 8'd128, 8'd129, 8'd255};

  // Offer one item, optionally after an idle burst, and log its expected
  // result at the accepting edge.
  task automatic send_tick(input logic [7:0] value, input ssd_mode_t mode,
                           input bit typed, input ssd_out_t typed_out);
    ssd_in_t tick;
    tick.shown_value  = value;
    tick.display_mode = mode;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_digits.push_back(typed ? typed_out : scan_pattern(tick, scan_pos));
    scan_pos = scan_pos + 2'd1;
  endtask

  // Hold the sender off until every outstanding result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, none started while idle_pct is zero
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: oldest expectation first, field by field
  always @(posedge clk) begin : result_check
    ssd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected result: segments=%h digit_enable=%b",
               out_data.segments, out_data.digit_enable);
        errors = errors + 1;
      end else begin
        want = expected_digits.pop_front();
        if (out_data.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, out_data.segments);
          errors = errors + 1;
        end
        if (out_data.digit_enable !== want.digit_enable) begin
          $error("digit_enable: expected %b, got %b",
                 want.digit_enable, out_data.digit_enable);
          errors = errors + 1;
        end
      end
    end
  end

  // Stimulus
  initial begin
    ssd_out_t  typed_out;
    logic [7:0] value;
    ssd_mode_t  mode;
    int         pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, moderate idling on both sides
    idle_pct = 15;
    foreach (tick_table[i]) begin
      typed_out.segments     = tick_table[i].seg;
      typed_out.digit_enable = tick_table[i].en;
      send_tick(tick_table[i].value, tick_table[i].mode, tick_table[i].typed, typed_out);
    end
    drain_results();

    // Random ticks; idle level changes every hundred items, some blocks
    // without any idling, and a quiet tail at the end
    for (int i = 0; i < RAND_TICKS; i++) begin
      if (i % 100 == 0) begin
        pick = $urandom_range(0, 3);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : (pick == 2) ? 15 : 35;
      end
      if (i >= RAND_TICKS - QUIET_TAIL) idle_pct = 0;
      if (i == RAND_TICKS / 2) drain_results();
      if ($urandom_range(0, 7) == 0) value = edge_values[$urandom_range(0, 9)];
      else value = 8'($urandom_range(0, 255));
      mode = ssd_mode_t'($urandom_range(0, 3));
      send_tick(value, mode, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Let the pipeline empty, then keep watching for anything stray
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (errors == 0) begin
      $display("** seven_segment_scan_driver_top: PASSED **");
    end else begin
      $display("** seven_segment_scan_driver_top: FAILED **");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("** seven_segment_scan_driver_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ssd_pkg.sv
rtl/core/ssd_decimal.sv
rtl/core/ssd_pattern.sv
rtl/core/seven_segment_scan_driver_top.sv
rtl/core/ssd_checker.sv
test/tb_seven_segment_scan_driver_top.sv
